@@ rtl/mtm_pkg.sv @@
// package for the member table merge block
// field widths, record type, event and register codes; no dependencies
`default_nettype none

package mtm_pkg;

  localparam int unsigned HOST_W  = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 8;

  // one gossiped record, also the word stored per table entry
  typedef struct packed {
    logic               alive;
    logic [STAMP_W-1:0] stamp;
    logic [PORT_W-1:0]  port;
    logic [HOST_W-1:0]  host;
  } record_t;

  localparam int unsigned REC_W = $bits(record_t);

  // event reported per record
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ADD    = 2'd1,
    EV_REMOVE = 2'd2,
    EV_FULL   = 2'd3
  } event_e;

  // configuration register indexes
  typedef enum logic {
    CFG_SELF_HOST = 1'b0,
    CFG_SELF_PORT = 1'b1
  } cfg_idx_e;

  // table port strobes from the sequencer
  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

endpackage

`default_nettype wire

@@ rtl/mtm_table.sv @@
// member table storage: one write port, one registered read port
// depends on mtm_pkg
`default_nettype none

module mtm_table
  import mtm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire                             clk_i,
  input  wire mem_req_t                   req_i,
  input  wire [$clog2(TABLE_DEPTH)-1:0]   waddr_i,
  input  wire record_t                    wdata_i,
  input  wire [$clog2(TABLE_DEPTH)-1:0]   raddr_i,
  output record_t                         rdata_o
);

  record_t mem_q [TABLE_DEPTH];
  record_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/mtm_seq.sv @@
// merge sequencer: walks the table one entry a cycle through a shared
// host/port compare, then updates or appends (or reports full); depends on mtm_pkg, mtm_table
`default_nettype none

module mtm_seq
  import mtm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire record_t        in_rec_i,
  input  wire [HOST_W-1:0]    self_host_i,
  input  wire [PORT_W-1:0]    self_port_i,
  output logic                done_o,
  output event_e              event_o,
  input  wire                 out_free_i
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CMP, ST_MISS, ST_DONE
  } state_e;

  state_e         state_q, state_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  record_t        rec_q, rec_d;
  event_e         ev_q, ev_d;

  mem_req_t       req;
  logic [AW-1:0]  waddr, raddr;
  record_t        wdata, rdata;
  logic           hit, last;

  mtm_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .req_i   (req),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared compare against the entry just read
  assign hit  = (rdata.host == rec_q.host) && (rdata.port == rec_q.port);
  assign last = ({1'b0, idx_q} + CW'(1)) == cnt_q;

  // next state and table access
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    rec_d      = rec_q;
    ev_d       = ev_q;
    req        = '0;
    waddr      = idx_q;
    raddr      = idx_q;
    wdata      = rec_q;
    in_ready_o = 1'b0;
    done_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rec_d = in_rec_i;
          idx_d = '0;
          if (in_rec_i.host == self_host_i && in_rec_i.port == self_port_i) begin
            ev_d    = EV_NONE;
            state_d = ST_DONE;
          end else if (cnt_q == '0) begin
            state_d = ST_MISS;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        req.re  = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (hit) begin
          wdata.host = rdata.host;
          wdata.port = rdata.port;
          ev_d       = EV_NONE;
          if (rdata.stamp < rec_q.stamp) begin
            req.we = 1'b1;
            if (rec_q.alive && !rdata.alive) begin
              ev_d = EV_ADD;
            end else if (!rec_q.alive && rdata.alive) begin
              ev_d = EV_REMOVE;
            end
          end else if (rdata.stamp == rec_q.stamp && !rec_q.alive && rdata.alive) begin
            // equal stamp dead record marks a live entry dead
            req.we      = 1'b1;
            wdata.stamp = rdata.stamp;
            ev_d        = EV_REMOVE;
          end
          state_d = ST_DONE;
        end else if (last) begin
          state_d = ST_MISS;
        end else begin
          // fetch the next entry while this one is being compared
          idx_d  = idx_q + AW'(1);
          raddr  = idx_q + AW'(1);
          req.re = 1'b1;
        end
      end
      ST_MISS: begin
        if (cnt_q == DEPTH_C) begin
          ev_d = EV_FULL;
        end else begin
          req.we = 1'b1;
          waddr  = cnt_q[AW-1:0];
          cnt_d  = cnt_q + CW'(1);
          ev_d   = rec_q.alive ? EV_ADD : EV_NONE;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      ev_q    <= EV_NONE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ev_q    <= ev_d;
    end
  end

  // record holding register
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign event_o = ev_q;

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("entry count above table depth");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.we |-> (state_q == ST_CMP || state_q == ST_MISS))
    else $error("table write outside update states");

  a_full_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MISS && cnt_q == DEPTH_C) |=> (ev_q == EV_FULL && cnt_q == DEPTH_C))
    else $error("full table did not report full");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat accepted while merging");

  a_search_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ({1'b0, idx_q} < cnt_q))
    else $error("search index beyond entry count");

endmodule

`default_nettype wire

@@ rtl/membership_table_merge_top.sv @@
// Member table merge top level: config registers, stream ports, output register.
// Event path: the sequencer searches the table one entry per cycle for the accepted record,
// then updates, appends or reports full, and its event goes to the output register that
// drives m_axis_tvalid; a self record skips the search.
// One record in flight: no beat is taken until the last event enters the output register.
// Reset (async, active low) empties the table and clears self regs.
`default_nettype none

module membership_table_merge_top
  import mtm_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // config write port
  input  wire                    cfg_we_i,
  input  wire                    cfg_idx_i,
  input  wire [CFG_W-1:0]        cfg_data_i,
  // input records
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  // member_host[31:0], member_port[47:32], member_stamp[79:48], member_alive[80]
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
  // events
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  // event_res[1:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [HOST_W-1:0] self_host_q;
  logic [PORT_W-1:0] self_port_q;
  logic              out_valid_q;
  event_e            out_ev_q;
  record_t           in_rec;
  logic              done, out_free;
  event_e            ev;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_host_q <= '0;
      self_port_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SELF_HOST: self_host_q <= cfg_data_i[HOST_W-1:0];
        CFG_SELF_PORT: self_port_q <= cfg_data_i[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack input beat
  assign in_rec.host  = s_axis_tdata[31:0];
  assign in_rec.port  = s_axis_tdata[47:32];
  assign in_rec.stamp = s_axis_tdata[79:48];
  assign in_rec.alive = s_axis_tdata[80];

  mtm_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_rec_i    (in_rec),
    .self_host_i (self_host_q),
    .self_port_i (self_port_q),
    .done_o      (done),
    .event_o     (ev),
    .out_free_i  (out_free)
  );

  // output register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_ev_q    <= EV_NONE;
    end else if (out_free) begin
      out_valid_q <= done;
      if (done) begin
        out_ev_q <= ev;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_ev_q};

endmodule

`default_nettype wire
